// ===== rtl/rcf_pkg.sv =====
// Shared types and constants for the RC packet to serial frame encoder.
package rcf_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       status;
  } out_item_t;

  typedef enum logic [1:0] {
    PROTO_MSPV1 = 2'd0,
    PROTO_MSPV2 = 2'd1,
    PROTO_SUMD  = 2'd2,
    PROTO_NONE  = 2'd3
  } proto_t;

  localparam logic [1:0] REG_OUT_PROTOCOL   = 2'd0;
  localparam logic [1:0] REG_SUMD_SCALE     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_OFFSET = 2'd2;
  localparam logic [1:0] REG_LINK_CRC_POLY  = 2'd3;

  localparam logic [7:0] SUMD_HDR0   = 8'ha8;
  localparam logic [7:0] SUMD_HDR1   = 8'h01;
  localparam logic [7:0] SUMD_NCH    = 8'h0c;
  localparam logic [7:0] MSP_DOLLAR  = 8'h24;
  localparam logic [7:0] MSP_V1_M    = 8'h4d;
  localparam logic [7:0] MSP_V2_X    = 8'h58;
  localparam logic [7:0] MSP_DIR     = 8'h3c;
  localparam logic [7:0] MSP_CMD_RC  = 8'hc8;
  localparam logic [7:0] MSP_PAYLOAD = 8'h18;
  localparam logic [7:0] DVB_S2_POLY = 8'hd5;
  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // Job handed from the front end to the frame builder.
  typedef struct packed {
    logic       err;
    logic [1:0] proto;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_LOAD  = 2'd1,
    BK_EMIT  = 2'd2
  } bk_state_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CCITT_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

endpackage

// ===== rtl/rcf_front.sv =====
// Front end: stores bytes, runs link CRC; job on byte 15 unless CRC ok and NONE.
module rcf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcf_pkg::in_item_t  in_data,
  input  logic [7:0]         poly,
  input  logic [1:0]         proto,
  output logic               job_valid,
  input  logic               job_take,
  output rcf_pkg::job_t      job,
  input  logic [3:0]         rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [16];
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       q_full_r;
  rcf_pkg::job_t q_r;
  logic [3:0] pos;
  logic       acc;

  // The one-entry queue holds a job while the builder still reads the store,
  // so a new packet is held off until the job is taken.
  assign in_stall = q_full_r;
  assign acc      = in_valid && !in_stall;
  assign pos      = in_data.packet_start ? 4'd0 : cnt_r;

  always_comb begin
    cnt_nxt = pos + 4'd1;
    crc_nxt = rcf_pkg::crc8_step((pos == 4'd0) ? 8'd0 : crc_r, in_data.data_byte, poly);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[pos] <= in_data.data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      crc_r    <= '0;
      q_full_r <= 1'b0;
    end else begin
      if (job_take) begin
        q_full_r <= 1'b0;
      end
      if (acc) begin
        cnt_r <= cnt_nxt;
        if (pos != 4'd15) begin
          crc_r <= crc_nxt;
        end else if (crc_r != in_data.data_byte
                     || proto != rcf_pkg::PROTO_NONE) begin
          q_full_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pos == 4'd15) begin
      q_r.err   <= (crc_r != in_data.data_byte);
      q_r.proto <= proto;
    end
  end

  assign job_valid = q_full_r;
  assign job       = q_r;

endmodule

// ===== rtl/rcf_back.sv =====
// Back end: unpacks channels; emits the chosen frame one byte per unstalled cycle.
module rcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_take,
  input  rcf_pkg::job_t      job,
  output logic [3:0]         rd_addr,
  input  logic [7:0]         rd_data,
  input  logic [5:0]         scale,
  input  logic [9:0]         offset,
  output logic               out_valid,
  input  logic               out_stall,
  output rcf_pkg::out_item_t out_data
);

  rcf_pkg::bk_state_t st_r, st_nxt;
  logic [4:0]  ld_r;          // load step: issues read ld_r, captures ld_r-1
  logic [119:0] bits_r;       // 15 packet bytes, little-endian bit stream
  logic [5:0]  idx_r;         // frame byte index
  logic [1:0]  proto_r;
  logic        err_r;
  logic [7:0]  x_r;           // running XOR or CRC-8
  logic [15:0] c16_r;
  logic        ov_r;
  rcf_pkg::out_item_t o_r;

  logic [5:0]  n_last;
  logic [3:0]  ch_idx;
  logic [9:0]  raw;
  logic [15:0] ch;
  logic [21:0] prod;
  logic [15:0] sv;
  logic [7:0]  b;
  logic        ch_lo;
  logic        push;

  assign push = (st_r == rcf_pkg::BK_EMIT) && (!ov_r || !out_stall);

  always_comb begin
    unique case (proto_r)
      rcf_pkg::PROTO_MSPV1: n_last = 6'd29;
      rcf_pkg::PROTO_MSPV2: n_last = 6'd32;
      default:              n_last = 6'd28;
    endcase
  end

  // Channel select for the current frame byte.
  always_comb begin
    logic [5:0] rel;
    unique case (proto_r)
      rcf_pkg::PROTO_MSPV1: rel = idx_r - 6'd5;
      rcf_pkg::PROTO_MSPV2: rel = idx_r - 6'd8;
      default:              rel = idx_r - 6'd3;
    endcase
    ch_idx = rel[4:1];
    ch_lo  = !rel[0];
    raw    = bits_r[ch_idx * 10 +: 10];
    ch     = {6'd0, raw} + {6'd0, offset};
    prod   = ch * scale;
    sv     = prod[15:0];
  end

  always_comb begin
    b = 8'd0;
    unique case (proto_r)
      rcf_pkg::PROTO_MSPV1: begin
        priority case (1'b1)
          idx_r == 6'd0: b = rcf_pkg::MSP_DOLLAR;
          idx_r == 6'd1: b = rcf_pkg::MSP_V1_M;
          idx_r == 6'd2: b = rcf_pkg::MSP_DIR;
          idx_r == 6'd3: b = rcf_pkg::MSP_PAYLOAD;
          idx_r == 6'd4: b = rcf_pkg::MSP_CMD_RC;
          idx_r == 6'd29: b = x_r;
          default: b = ch_lo ? ch[7:0] : ch[15:8];
        endcase
      end
      rcf_pkg::PROTO_MSPV2: begin
        priority case (1'b1)
          idx_r == 6'd0: b = rcf_pkg::MSP_DOLLAR;
          idx_r == 6'd1: b = rcf_pkg::MSP_V2_X;
          idx_r == 6'd2: b = rcf_pkg::MSP_DIR;
          idx_r == 6'd4: b = rcf_pkg::MSP_CMD_RC;
          idx_r == 6'd6: b = rcf_pkg::MSP_PAYLOAD;
          idx_r < 6'd8:  b = 8'd0;
          idx_r == 6'd32: b = x_r;
          default: b = ch_lo ? ch[7:0] : ch[15:8];
        endcase
      end
      default: begin
        priority case (1'b1)
          idx_r == 6'd0: b = rcf_pkg::SUMD_HDR0;
          idx_r == 6'd1: b = rcf_pkg::SUMD_HDR1;
          idx_r == 6'd2: b = rcf_pkg::SUMD_NCH;
          idx_r == 6'd27: b = c16_r[15:8];
          idx_r == 6'd28: b = c16_r[7:0];
          default: b = ch_lo ? sv[15:8] : sv[7:0];
        endcase
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rcf_pkg::BK_IDLE: if (job_valid) st_nxt = rcf_pkg::BK_LOAD;
      rcf_pkg::BK_LOAD: if (ld_r == 5'd15) st_nxt = rcf_pkg::BK_EMIT;
      rcf_pkg::BK_EMIT: if (push && (err_r || idx_r == n_last)) st_nxt = rcf_pkg::BK_IDLE;
      default: st_nxt = rcf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_take = (st_r == rcf_pkg::BK_LOAD) && (ld_r == 5'd15);
    rd_addr  = ld_r[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rcf_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (push) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == rcf_pkg::BK_IDLE) begin
      ld_r    <= '0;
      idx_r   <= '0;
      x_r     <= '0;
      c16_r   <= '0;
      proto_r <= job.proto;
      err_r   <= job.err;
    end else if (st_r == rcf_pkg::BK_LOAD) begin
      ld_r <= ld_r + 5'd1;
      if (ld_r != 5'd0) begin
        bits_r <= {rd_data, bits_r[119:8]};
      end
    end
    if (push) begin
      idx_r <= idx_r + 6'd1;
      if (proto_r == rcf_pkg::PROTO_MSPV1 && idx_r >= 6'd3) x_r <= x_r ^ b;
      if (proto_r == rcf_pkg::PROTO_MSPV2 && idx_r >= 6'd3)
        x_r <= rcf_pkg::crc8_step(x_r, b, rcf_pkg::DVB_S2_POLY);
      // The SUMD CRC covers bytes 0..26 only; it must hold while its two bytes go out.
      if (idx_r < 6'd27) c16_r <= rcf_pkg::crc16_step(c16_r, b);
      o_r.out_byte <= err_r ? 8'd0 : b;
      o_r.out_last <= err_r || (idx_r == n_last);
      o_r.status   <= err_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;

endmodule

// ===== rtl/rc_packet_to_serial_frame_core.sv =====
// Top level of the RC packet to serial frame encoder.
// One packet byte is taken per cycle while in_stall is low; bytes 0..14 give no
// output. On byte 15 the front end checks the link CRC-8 and queues a job, unless
// the CRC matches and the protocol is NONE; the back end reads the 15 stored bytes
// through the packet store's single read port and then emits one frame byte per
// unstalled cycle: 30 (MSPv1), 33 (MSPv2) or 29 (SUMD), or one error item on a
// CRC mismatch. The input is held off after byte 15 until the back end has loaded
// the bytes; the next packet's job then waits for the frame to finish.
module rc_packet_to_serial_frame_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [1:0] proto_r;
  logic [5:0] scale_r;
  logic [9:0] offset_r;
  logic [7:0] poly_r;
  logic       job_valid, job_take;
  rcf_pkg::job_t job;
  logic [3:0] rd_addr;
  logic [7:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r  <= rcf_pkg::PROTO_MSPV1;
      scale_r  <= 6'd8;
      offset_r <= 10'd1000;
      poly_r   <= 8'd213;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcf_pkg::REG_OUT_PROTOCOL:   proto_r  <= cfg_wdata[1:0];
        rcf_pkg::REG_SUMD_SCALE:     scale_r  <= cfg_wdata[5:0];
        rcf_pkg::REG_CHANNEL_OFFSET: offset_r <= cfg_wdata[9:0];
        default:                     poly_r   <= cfg_wdata[7:0];
      endcase
    end
  end

  rcf_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .poly(poly_r), .proto(proto_r),
    .job_valid, .job_take, .job, .rd_addr, .rd_data
  );

  rcf_back u_back (
    .clk, .rst_n, .job_valid, .job_take, .job, .rd_addr, .rd_data,
    .scale(scale_r), .offset(offset_r),
    .out_valid, .out_stall, .out_data
  );

  a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("job taken with empty queue");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.out_last && out_data.out_byte == 8'd0))
    else $error("error item malformed");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
